// ===== hdl/cle_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cle_pkg: shared types and constants for the circular list engine
// Command and status codes, payload structs, and the controller/datapath
// command and status types.
// ----------------------------------------------------------------------------
package cle_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam logic [2:0] CMD_INS_FRONT = 3'd0;
    localparam logic [2:0] CMD_INS_BACK  = 3'd1;
    localparam logic [2:0] CMD_INS_AT    = 3'd2;
    localparam logic [2:0] CMD_DEL_FRONT = 3'd3;
    localparam logic [2:0] CMD_DEL_BACK  = 3'd4;
    localparam logic [2:0] CMD_DEL_AT    = 3'd5;
    localparam logic [2:0] CMD_LIST      = 3'd6;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_BAD   = 2'd3;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] value;
        logic [4:0]         position;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] value_out;
        logic [1:0]         status;
        logic               last;
        logic [4:0]         element_count;
    } out_item_t;

    // What the decoded command turns into
    typedef enum logic [3:0] {
        K_STATUS,
        K_INS_FRONT,
        K_INS_BACK,
        K_INS_MID,
        K_DEL_ONLY,
        K_DEL_FRONT,
        K_DEL_BACK,
        K_DEL_MID,
        K_LIST
    } kind_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_DECIDE,
        DP_RD_CUR,
        DP_ADV,
        DP_GRAB_A,
        DP_RD_TMP,
        DP_GRAB_B,
        DP_C1,
        DP_C2,
        DP_EMIT_STATUS,
        DP_EMIT_LIST
    } dp_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_ROUTE,
        S_WALK_RD,
        S_WALK_ADV,
        S_RD_CUR,
        S_GRAB_A,
        S_RD_TMP,
        S_GRAB_B,
        S_C1,
        S_C2,
        S_FINISH,
        S_LIST_RD,
        S_LIST_EMIT
    } state_t;

    typedef struct packed {
        dp_op_t op;
    } ctl_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  steps_zero;
        logic  steps_one;
        logic  out_free;
    } dp_stat_t;

endpackage
`default_nettype wire

// ===== hdl/cle_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cle_ram: generic single-write, single-read RAM
// Registered read data; the read register holds when no read is issued.
// ----------------------------------------------------------------------------
module cle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== hdl/cle_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cle_ctrl: sequencer for the circular list engine
// Steps each command through decode, pointer walk, link updates and emit.
// ----------------------------------------------------------------------------
module cle_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    output logic                   cmd_stall,
    input  wire cle_pkg::dp_stat_t stat,
    output cle_pkg::ctl_cmd_t      ctl
);

    cle_pkg::state_t state_reg, state_next;
    cle_pkg::state_t post_walk;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cle_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign post_walk = (stat.kind == cle_pkg::K_DEL_BACK) ? cle_pkg::S_C1 : cle_pkg::S_RD_CUR;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cle_pkg::S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = cle_pkg::S_DECIDE;
                end
            end
            cle_pkg::S_DECIDE:   state_next = cle_pkg::S_ROUTE;
            cle_pkg::S_ROUTE:
            begin
                case (stat.kind) inside
                    cle_pkg::K_STATUS:    state_next = cle_pkg::S_FINISH;
                    cle_pkg::K_DEL_FRONT: state_next = cle_pkg::S_RD_CUR;
                    cle_pkg::K_LIST:      state_next = cle_pkg::S_LIST_RD;
                    cle_pkg::K_INS_MID, cle_pkg::K_DEL_BACK, cle_pkg::K_DEL_MID:
                        state_next = stat.steps_zero ? post_walk : cle_pkg::S_WALK_RD;
                    default:              state_next = cle_pkg::S_C1;
                endcase
            end
            cle_pkg::S_WALK_RD:  state_next = cle_pkg::S_WALK_ADV;
            cle_pkg::S_WALK_ADV: state_next = stat.steps_one ? post_walk : cle_pkg::S_WALK_RD;
            cle_pkg::S_RD_CUR:   state_next = cle_pkg::S_GRAB_A;
            cle_pkg::S_GRAB_A:
                state_next = (stat.kind == cle_pkg::K_DEL_MID) ? cle_pkg::S_RD_TMP
                                                                : cle_pkg::S_C1;
            cle_pkg::S_RD_TMP:   state_next = cle_pkg::S_GRAB_B;
            cle_pkg::S_GRAB_B:   state_next = cle_pkg::S_C1;
            cle_pkg::S_C1:       state_next = cle_pkg::S_C2;
            cle_pkg::S_C2:       state_next = cle_pkg::S_FINISH;
            cle_pkg::S_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = cle_pkg::S_IDLE;
                end
            end
            cle_pkg::S_LIST_RD:  state_next = cle_pkg::S_LIST_EMIT;
            cle_pkg::S_LIST_EMIT:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.steps_one ? cle_pkg::S_IDLE : cle_pkg::S_LIST_RD;
                end
            end
            default:             state_next = cle_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        ctl.op = cle_pkg::DP_NOP;
        unique case (state_reg)
            cle_pkg::S_IDLE:      ctl.op = cmd_valid ? cle_pkg::DP_LOAD : cle_pkg::DP_NOP;
            cle_pkg::S_DECIDE:    ctl.op = cle_pkg::DP_DECIDE;
            cle_pkg::S_WALK_RD:   ctl.op = cle_pkg::DP_RD_CUR;
            cle_pkg::S_WALK_ADV:  ctl.op = cle_pkg::DP_ADV;
            cle_pkg::S_RD_CUR:    ctl.op = cle_pkg::DP_RD_CUR;
            cle_pkg::S_GRAB_A:    ctl.op = cle_pkg::DP_GRAB_A;
            cle_pkg::S_RD_TMP:    ctl.op = cle_pkg::DP_RD_TMP;
            cle_pkg::S_GRAB_B:    ctl.op = cle_pkg::DP_GRAB_B;
            cle_pkg::S_C1:        ctl.op = cle_pkg::DP_C1;
            cle_pkg::S_C2:        ctl.op = cle_pkg::DP_C2;
            cle_pkg::S_FINISH:
                ctl.op = stat.out_free ? cle_pkg::DP_EMIT_STATUS : cle_pkg::DP_NOP;
            cle_pkg::S_LIST_RD:   ctl.op = cle_pkg::DP_RD_CUR;
            cle_pkg::S_LIST_EMIT:
                ctl.op = stat.out_free ? cle_pkg::DP_EMIT_LIST : cle_pkg::DP_NOP;
            default:              ctl.op = cle_pkg::DP_NOP;
        endcase
    end

    assign cmd_stall = (state_reg != cle_pkg::S_IDLE);

endmodule
`default_nettype wire

// ===== hdl/cle_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cle_dp: datapath of the circular list engine
// Node value and link stores, free map, head/tail/count, walk cursor and
// the result register.
// ----------------------------------------------------------------------------
module cle_dp #(
    parameter int CAPACITY = cle_pkg::CAPACITY_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cle_pkg::in_item_t cmd_data,
    input  wire cle_pkg::ctl_cmd_t ctl,
    output cle_pkg::dp_stat_t      stat,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output cle_pkg::out_item_t     rsp_data
);

    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = ((CNT_W > 5) ? CNT_W : 5) + 1;

    logic [2:0]         cmd_reg;
    logic signed [31:0] val_reg;
    logic [4:0]         pos_reg;

    logic [CAPACITY-1:0] free_reg, free_next;
    logic [SLOT_W-1:0]   head_reg, head_next;
    logic [SLOT_W-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [SLOT_W-1:0]   cur_reg;
    logic [SLOT_W-1:0]   tmp_reg;
    logic [SLOT_W-1:0]   nx_reg;
    logic [CNT_W-1:0]    steps_reg;
    cle_pkg::kind_t      kind_reg, kind_next;
    logic [1:0]          st_reg, st_next;
    logic [CNT_W-1:0]    hops;

    logic                out_valid_reg;
    cle_pkg::out_item_t  out_reg;
    logic                out_free;

    logic                lnk_we, val_we, rd_en;
    logic [SLOT_W-1:0]   lnk_waddr, lnk_wdata, rd_addr, lnk_rdata;
    logic [31:0]         val_rdata;
    logic [SLOT_W-1:0]   new_slot;
    logic [CMP_W-1:0]    pos_e, cnt_e;
    logic                is_full, is_empty, is_one;

    function automatic logic [SLOT_W-1:0] low_free(input logic [CAPACITY-1:0] m);
        logic [SLOT_W-1:0] r;
        r = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (m[i])
            begin
                r = SLOT_W'(i);
            end
        end
        return r;
    endfunction

    assign new_slot = low_free(free_reg);
    assign pos_e    = CMP_W'(pos_reg);
    assign cnt_e    = CMP_W'(count_reg);
    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);
    assign is_one   = (count_reg == CNT_W'(1));

    // decode the held command against the current list
    always_comb
    begin
        kind_next = cle_pkg::K_STATUS;
        st_next   = cle_pkg::ST_OK;
        hops      = '0;
        unique case (cmd_reg) inside
            cle_pkg::CMD_INS_FRONT, cle_pkg::CMD_INS_BACK:
            begin
                if (is_full)
                begin
                    st_next = cle_pkg::ST_FULL;
                end
                else if (cmd_reg == cle_pkg::CMD_INS_FRONT || is_empty)
                begin
                    kind_next = cle_pkg::K_INS_FRONT;
                end
                else
                begin
                    kind_next = cle_pkg::K_INS_BACK;
                end
            end
            cle_pkg::CMD_INS_AT:
            begin
                if (is_full)
                begin
                    st_next = cle_pkg::ST_FULL;
                end
                else if (pos_e == '0 || pos_e > cnt_e + CMP_W'(1))
                begin
                    st_next = cle_pkg::ST_BAD;
                end
                else if (pos_e == CMP_W'(1))
                begin
                    kind_next = cle_pkg::K_INS_FRONT;
                end
                else if (pos_e == cnt_e + CMP_W'(1))
                begin
                    kind_next = cle_pkg::K_INS_BACK;
                end
                else
                begin
                    kind_next = cle_pkg::K_INS_MID;
                    hops      = CNT_W'(pos_e - CMP_W'(2));
                end
            end
            cle_pkg::CMD_DEL_FRONT, cle_pkg::CMD_DEL_BACK:
            begin
                if (is_empty)
                begin
                    st_next = cle_pkg::ST_EMPTY;
                end
                else if (is_one)
                begin
                    kind_next = cle_pkg::K_DEL_ONLY;
                end
                else if (cmd_reg == cle_pkg::CMD_DEL_FRONT)
                begin
                    kind_next = cle_pkg::K_DEL_FRONT;
                end
                else
                begin
                    kind_next = cle_pkg::K_DEL_BACK;
                    hops      = count_reg - CNT_W'(2);
                end
            end
            cle_pkg::CMD_DEL_AT:
            begin
                if (is_empty)
                begin
                    st_next = cle_pkg::ST_EMPTY;
                end
                else if (pos_e == '0 || pos_e > cnt_e)
                begin
                    st_next = cle_pkg::ST_BAD;
                end
                else if (is_one)
                begin
                    kind_next = cle_pkg::K_DEL_ONLY;
                end
                else if (pos_e == CMP_W'(1))
                begin
                    kind_next = cle_pkg::K_DEL_FRONT;
                end
                else if (pos_e == cnt_e)
                begin
                    kind_next = cle_pkg::K_DEL_BACK;
                    hops      = count_reg - CNT_W'(2);
                end
                else
                begin
                    kind_next = cle_pkg::K_DEL_MID;
                    hops      = CNT_W'(pos_e - CMP_W'(2));
                end
            end
            cle_pkg::CMD_LIST:
            begin
                if (is_empty)
                begin
                    st_next = cle_pkg::ST_EMPTY;
                end
                else
                begin
                    kind_next = cle_pkg::K_LIST;
                    hops      = count_reg;
                end
            end
            default:
            begin
                st_next = cle_pkg::ST_OK;
            end
        endcase
    end

    // store access per operation
    always_comb
    begin
        rd_en     = 1'b0;
        rd_addr   = cur_reg;
        lnk_we    = 1'b0;
        lnk_waddr = new_slot;
        lnk_wdata = head_reg;
        val_we    = 1'b0;
        case (ctl.op)
            cle_pkg::DP_RD_CUR:
            begin
                rd_en = 1'b1;
            end
            cle_pkg::DP_RD_TMP:
            begin
                rd_en   = 1'b1;
                rd_addr = tmp_reg;
            end
            cle_pkg::DP_C1:
            begin
                case (kind_reg)
                    cle_pkg::K_INS_FRONT:
                    begin
                        lnk_we    = 1'b1;
                        val_we    = 1'b1;
                        lnk_wdata = is_empty ? new_slot : head_reg;
                    end
                    cle_pkg::K_INS_BACK:
                    begin
                        lnk_we = 1'b1;
                        val_we = 1'b1;
                    end
                    cle_pkg::K_INS_MID:
                    begin
                        lnk_we    = 1'b1;
                        val_we    = 1'b1;
                        lnk_wdata = tmp_reg;
                    end
                    cle_pkg::K_DEL_FRONT:
                    begin
                        lnk_we    = 1'b1;
                        lnk_waddr = tail_reg;
                        lnk_wdata = tmp_reg;
                    end
                    cle_pkg::K_DEL_BACK:
                    begin
                        lnk_we    = 1'b1;
                        lnk_waddr = cur_reg;
                    end
                    cle_pkg::K_DEL_MID:
                    begin
                        lnk_we    = 1'b1;
                        lnk_waddr = cur_reg;
                        lnk_wdata = nx_reg;
                    end
                    default:
                    begin
                        lnk_we = 1'b0;
                    end
                endcase
            end
            cle_pkg::DP_C2:
            begin
                lnk_wdata = new_slot;
                case (kind_reg)
                    cle_pkg::K_INS_FRONT:
                    begin
                        lnk_we    = !is_empty;
                        lnk_waddr = tail_reg;
                    end
                    cle_pkg::K_INS_BACK:
                    begin
                        lnk_we    = 1'b1;
                        lnk_waddr = tail_reg;
                    end
                    cle_pkg::K_INS_MID:
                    begin
                        lnk_we    = 1'b1;
                        lnk_waddr = cur_reg;
                    end
                    default:
                    begin
                        lnk_we = 1'b0;
                    end
                endcase
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // list state commits in the second update cycle
    always_comb
    begin
        free_next  = free_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (ctl.op == cle_pkg::DP_C2)
        begin
            case (kind_reg)
                cle_pkg::K_INS_FRONT:
                begin
                    free_next[new_slot] = 1'b0;
                    head_next           = new_slot;
                    tail_next           = is_empty ? new_slot : tail_reg;
                    count_next          = count_reg + CNT_W'(1);
                end
                cle_pkg::K_INS_BACK:
                begin
                    free_next[new_slot] = 1'b0;
                    tail_next           = new_slot;
                    count_next          = count_reg + CNT_W'(1);
                end
                cle_pkg::K_INS_MID:
                begin
                    free_next[new_slot] = 1'b0;
                    count_next          = count_reg + CNT_W'(1);
                end
                cle_pkg::K_DEL_ONLY:
                begin
                    free_next[head_reg] = 1'b1;
                    head_next           = '0;
                    tail_next           = '0;
                    count_next          = '0;
                end
                cle_pkg::K_DEL_FRONT:
                begin
                    free_next[head_reg] = 1'b1;
                    head_next           = tmp_reg;
                    count_next          = count_reg - CNT_W'(1);
                end
                cle_pkg::K_DEL_BACK:
                begin
                    free_next[tail_reg] = 1'b1;
                    tail_next           = cur_reg;
                    count_next          = count_reg - CNT_W'(1);
                end
                cle_pkg::K_DEL_MID:
                begin
                    free_next[tmp_reg] = 1'b1;
                    count_next         = count_reg - CNT_W'(1);
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg      <= '1;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            kind_reg      <= cle_pkg::K_STATUS;
            st_reg        <= cle_pkg::ST_OK;
            steps_reg     <= '0;
        end
        else
        begin
            free_reg  <= free_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            if (ctl.op == cle_pkg::DP_DECIDE)
            begin
                kind_reg  <= kind_next;
                st_reg    <= st_next;
                steps_reg <= hops;
            end
            else if (ctl.op == cle_pkg::DP_ADV || ctl.op == cle_pkg::DP_EMIT_LIST)
            begin
                steps_reg <= steps_reg - CNT_W'(1);
            end
            if (ctl.op == cle_pkg::DP_EMIT_STATUS || ctl.op == cle_pkg::DP_EMIT_LIST)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctl.op)
            cle_pkg::DP_LOAD:
            begin
                cmd_reg <= cmd_data.command;
                val_reg <= cmd_data.value;
                pos_reg <= cmd_data.position;
            end
            cle_pkg::DP_DECIDE:  cur_reg <= head_reg;
            cle_pkg::DP_ADV:     cur_reg <= lnk_rdata;
            cle_pkg::DP_GRAB_A:  tmp_reg <= lnk_rdata;
            cle_pkg::DP_GRAB_B:  nx_reg  <= lnk_rdata;
            cle_pkg::DP_EMIT_STATUS:
            begin
                out_reg.value_out     <= '0;
                out_reg.status        <= st_reg;
                out_reg.last          <= 1'b1;
                out_reg.element_count <= cnt_e[4:0];
            end
            cle_pkg::DP_EMIT_LIST:
            begin
                cur_reg               <= lnk_rdata;
                out_reg.value_out     <= val_rdata;
                out_reg.status        <= cle_pkg::ST_OK;
                out_reg.last          <= (steps_reg == CNT_W'(1));
                out_reg.element_count <= cnt_e[4:0];
            end
            default:
            begin
                cur_reg <= cur_reg;
            end
        endcase
    end

    cle_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_links (
        .clk     (clk),
        .wr_en   (lnk_we),
        .wr_addr (lnk_waddr),
        .wr_data (lnk_wdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (lnk_rdata)
    );

    cle_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_values (
        .clk     (clk),
        .wr_en   (val_we),
        .wr_addr (new_slot),
        .wr_data (val_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (val_rdata)
    );

    assign out_free        = !out_valid_reg || !rsp_stall;
    assign stat.kind       = kind_reg;
    assign stat.steps_zero = (steps_reg == '0);
    assign stat.steps_one  = (steps_reg == CNT_W'(1));
    assign stat.out_free   = out_free;
    assign rsp_valid       = out_valid_reg;
    assign rsp_data        = out_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    a_free_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(~free_reg) == int'(count_reg))
        else $error("free map disagrees with element count");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (head_reg == '0 && tail_reg == '0))
        else $error("empty list with nonzero head or tail");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.op == cle_pkg::DP_EMIT_STATUS || ctl.op == cle_pkg::DP_EMIT_LIST)
        |-> out_free)
        else $error("result emitted over a held beat");

endmodule
`default_nettype wire

// ===== hdl/circular_list_engine_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// circular_list_engine_core: bounded circular singly linked list engine
// Node store in two RAMs (values, next links), a free map and head/tail/
// count registers, driven by a command sequencer.
// ----------------------------------------------------------------------------
//
//  channel | valid     | stall     | payload  | beat
//  --------+-----------+-----------+----------+----------------------------
//  command | cmd_valid | cmd_stall | cmd_data | one command per beat
//  result  | rsp_valid | rsp_stall | rsp_data | one status or list element
//
//  A command is decoded, then walks the links one pointer hop at a time
//  (a link read, then an advance; up to CAPACITY-2 hops) when it needs to,
//  then does its link reads and writes and emits its status beat.
//  List reads each element's link and value, then emits it.
//  The link RAM has a single read port, so each hop and each element needs its own read.
//  Reset marks every slot free and clears head, tail and count; the RAMs need no clear.
//  A stalled result stage holds the sequencer in its emit state.
//
module circular_list_engine_core #(
    parameter int CAPACITY = cle_pkg::CAPACITY_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    output logic                   cmd_stall,
    input  wire cle_pkg::in_item_t cmd_data,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output cle_pkg::out_item_t     rsp_data
);

    // command and status between sequencer and datapath
    cle_pkg::ctl_cmd_t ctl;
    cle_pkg::dp_stat_t stat;

    // sequencer: decode, walk, update, emit
    cle_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .stat      (stat),
        .ctl       (ctl)
    );

    // datapath: node stores, pointers, result register
    cle_dp #(.CAPACITY(CAPACITY)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_data  (cmd_data),
        .ctl       (ctl),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the circular list engine core
// Drives insert, delete and list commands over the command channel, keeps a
// shadow circular list, and checks every result beat in order against it.
// ----------------------------------------------------------------------------

class list_scoreboard;
    localparam int CAP = cle_pkg::CAPACITY_DEF;
    logic signed [31:0]  shadow[$];   // list contents, head first
    cle_pkg::out_item_t  pending[$];
    int                  errors;
    int                  checked;

    function new();
        errors  = 0;
        checked = 0;
    endfunction

    // Work out the result beats of one accepted command
    function void note_command(cle_pkg::in_item_t c);
        logic [1:0]         st;
        int                 n;
        cle_pkg::out_item_t r;
        st = cle_pkg::ST_OK;
        n  = shadow.size();
        case (c.command) inside
            cle_pkg::CMD_INS_FRONT, cle_pkg::CMD_INS_BACK, cle_pkg::CMD_INS_AT:
            begin
                if (n >= CAP)
                    st = cle_pkg::ST_FULL;
                else if (c.command == cle_pkg::CMD_INS_FRONT)
                    shadow.push_front(c.value);
                else if (c.command == cle_pkg::CMD_INS_BACK)
                    shadow.push_back(c.value);
                else if (c.position < 1 || c.position > n + 1)
                    st = cle_pkg::ST_BAD;
                else
                    shadow.insert(c.position - 1, c.value);
            end
            cle_pkg::CMD_DEL_FRONT, cle_pkg::CMD_DEL_BACK, cle_pkg::CMD_DEL_AT:
            begin
                if (n == 0)
                    st = cle_pkg::ST_EMPTY;
                else if (c.command == cle_pkg::CMD_DEL_FRONT)
                    void'(shadow.pop_front());
                else if (c.command == cle_pkg::CMD_DEL_BACK)
                    void'(shadow.pop_back());
                else if (c.position < 1 || c.position > n)
                    st = cle_pkg::ST_BAD;
                else
                    shadow.delete(c.position - 1);
            end
            cle_pkg::CMD_LIST:
            begin
                if (n == 0)
                    st = cle_pkg::ST_EMPTY;
                else
                begin
                    for (int k = 0; k < n; k++)
                    begin
                        r.value_out     = shadow[k];
                        r.status        = cle_pkg::ST_OK;
                        r.last          = (k == n - 1);
                        r.element_count = 5'(n);
                        pending.push_back(r);
                    end
                    return;
                end
            end
            default: ;
        endcase
        r.value_out     = '0;
        r.status        = st;
        r.last          = 1'b1;
        r.element_count = 5'(shadow.size());
        pending.push_back(r);
    endfunction

    function void check_result(cle_pkg::out_item_t a);
        cle_pkg::out_item_t e;
        checked++;
        if (pending.size() == 0)
        begin
            $error("unexpected result beat %h", a);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (a.value_out !== e.value_out)
        begin
            $error("value_out: expected %0d, got %0d", e.value_out, a.value_out);
            errors++;
        end
        if (a.status !== e.status)
        begin
            $error("status: expected %0d, got %0d", e.status, a.status);
            errors++;
        end
        if (a.last !== e.last)
        begin
            $error("last: expected %0d, got %0d", e.last, a.last);
            errors++;
        end
        if (a.element_count !== e.element_count)
        begin
            $error("element_count: expected %0d, got %0d",
                   e.element_count, a.element_count);
            errors++;
        end
    endfunction
endclass

module tb_top;
    localparam int         CYCLE_LIMIT = 400000;
    localparam logic [2:0] CMD_SPARE   = 3'd7;   // unused command code

    logic               clk;
    logic               rst_n;
    logic               cmd_valid;
    logic               cmd_stall;
    cle_pkg::in_item_t  cmd_data;
    logic               rsp_valid;
    logic               rsp_stall;
    cle_pkg::out_item_t rsp_data;

    list_scoreboard sb;
    int send_idle_pct;   // sender gap odds per cycle
    int recv_stall_pct;  // receiver stall odds per cycle
    int cycles;
    int sent;

    circular_list_engine_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: check each accepted beat, then pick the next stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
                sb.check_result(rsp_data);
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    // Present one command beat; hold it until accepted, with random gaps before
    task automatic send_beat(input logic [2:0] c, input logic signed [31:0] v,
                             input logic [4:0] p);
        cle_pkg::in_item_t it;
        it.command  = c;
        it.value    = v;
        it.position = p;
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_data  <= it;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        sb.note_command(it);
        sent++;
    endtask

    task automatic drain();
        cmd_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // Random command; mostly well-formed positions, occasional out of range
    task automatic send_random();
        int n;
        logic [2:0] c;
        logic [4:0] p;
        logic signed [31:0] v;
        n = sb.shadow.size();
        case ($urandom_range(9)) inside
            0, 1:    c = cle_pkg::CMD_INS_FRONT;
            2, 3:    c = cle_pkg::CMD_INS_BACK;
            4, 5:    c = cle_pkg::CMD_INS_AT;
            6:       c = cle_pkg::CMD_DEL_FRONT;
            7:       c = cle_pkg::CMD_DEL_BACK;
            8:       c = cle_pkg::CMD_DEL_AT;
            default: c = ($urandom_range(3) == 0) ? CMD_SPARE : cle_pkg::CMD_LIST;
        endcase
        // lean toward deletes when nearly full so the count moves both ways
        if (n >= 14 && c <= cle_pkg::CMD_INS_AT && $urandom_range(1))
            c = cle_pkg::CMD_DEL_AT;
        if ($urandom_range(7) == 0)
            p = 5'($urandom);
        else
            p = 5'($urandom_range(n + 1, 1));
        v = $urandom;
        send_beat(c, v, p);
    endtask

    initial
    begin
        sb             = new();
        cycles         = 0;
        sent           = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rst_n          = 1'b0;
        cmd_valid      = 1'b0;
        cmd_data       = '0;
        rsp_stall      = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty cases, extremes, full list, every command
        send_beat(cle_pkg::CMD_LIST, 0, 0);
        send_beat(cle_pkg::CMD_DEL_FRONT, 0, 1);
        send_beat(cle_pkg::CMD_DEL_AT, 0, 0);
        send_beat(cle_pkg::CMD_INS_BACK, 32'sh7fffffff, 0);
        send_beat(cle_pkg::CMD_DEL_BACK, 0, 0);
        send_beat(cle_pkg::CMD_INS_AT, 32'sh80000000, 0);
        send_beat(cle_pkg::CMD_INS_AT, 32'sh80000000, 5'd1);
        send_beat(cle_pkg::CMD_INS_AT, -1, 5'd2);
        send_beat(cle_pkg::CMD_INS_AT, 5, 5'd31);
        send_beat(cle_pkg::CMD_INS_AT, 6, 5'd2);
        send_beat(cle_pkg::CMD_LIST, 0, 0);
        send_beat(cle_pkg::CMD_DEL_AT, 0, 5'd2);
        send_beat(cle_pkg::CMD_DEL_AT, 0, 5'd4);
        send_beat(cle_pkg::CMD_DEL_AT, 0, 5'd2);
        send_beat(CMD_SPARE, 0, 0);
        for (int i = 0; i < 15; i++)
            send_beat(cle_pkg::CMD_INS_FRONT, i, 0);
        send_beat(cle_pkg::CMD_INS_AT, 99, 5'd17);
        send_beat(cle_pkg::CMD_LIST, 0, 0);
        send_beat(cle_pkg::CMD_INS_BACK, 1, 0);
        send_beat(cle_pkg::CMD_INS_AT, 2, 5'd3);
        send_beat(cle_pkg::CMD_DEL_AT, 0, 5'd16);
        send_beat(cle_pkg::CMD_DEL_AT, 0, 5'd17);

        // Hold off the sender until every expected beat has come
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            for (int i = 0; i < 70; i++)
                send_random();
        end

        send_beat(cle_pkg::CMD_LIST, 0, 0);
        drain();

        $display("sent %0d commands, checked %0d result beats over four idle mixes",
                 sent, sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/cle_pkg.sv
hdl/cle_ram.sv
hdl/cle_ctrl.sv
hdl/cle_dp.sv
hdl/circular_list_engine_core.sv
verif/tb_top.sv
